// ===== src/trapezoid_union_pixel_mask_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for trapezoid_union_pixel_mask_core
// Clocked assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_UNION_PIXEL_MASK_CORE_ASSERT_SVH
`define TRAPEZOID_UNION_PIXEL_MASK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// check an implication on every clock edge outside reset
`define TUPM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that a condition never holds outside reset
`define TUPM_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TUPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define TUPM_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/tupm_pkg.sv =====
// ----------------------------------------------------------------------------
// tupm_pkg
// Shared types, constants and helpers of the trapezoid pixel mask core.
// ----------------------------------------------------------------------------
package tupm_pkg;

	localparam int COORD_W   = 17;
	localparam int SIZE_W    = 13;
	localparam int PXL_W     = 29;
	localparam int SLOPE_W   = 32;
	localparam int DIV_NUM_W = 45;
	localparam int DIV_DEN_W = 29;
	localparam int DYH_W     = 30;

	localparam logic [COORD_W-1:0] ONE_Q16  = 17'h10000;
	localparam logic [SIZE_W-1:0]  SIZE_MAX = 13'd4096;

	// configuration register indexes
	localparam logic [1:0] CFG_SHAPE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SHAPE_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_SCAN_WIDTH   = 2'd2;
	localparam logic [1:0] CFG_QUAD_COUNT   = 2'd3;

	// input operations
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LMUL,
		ST_DTS,
		ST_DTW,
		ST_DBS,
		ST_DBW,
		ST_LWR,
		ST_TGO,
		ST_TRUN,
		ST_DONE
	} tupm_state_t;

	// test word moving along the cell chain
	typedef struct packed {
		logic vld;
		logic hit;
	} tupm_tok_t;

	// slot write broadcast to the cells
	typedef struct packed {
		logic                      we;
		logic [3:0]                slot;
		logic [PXL_W-1:0]          left;
		logic [PXL_W-1:0]          right;
		logic [PXL_W-1:0]          tstart;
		logic [PXL_W-1:0]          bstart;
		logic signed [SLOPE_W-1:0] tslope;
		logic signed [SLOPE_W-1:0] bslope;
		logic                      empty;
	} tupm_wr_t;

	function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v);
		return (v > SIZE_MAX) ? SIZE_MAX : v;
	endfunction

endpackage

// ===== src/tupm_div.sv =====
// ----------------------------------------------------------------------------
// tupm_div
// Restoring divider, one quotient bit per cycle, with signed saturation.
// ----------------------------------------------------------------------------
module tupm_div import tupm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DIV_NUM_W-1:0]      num,
	input  logic                      neg,
	input  logic [DIV_DEN_W-1:0]      den,
	output logic                      done,
	output logic signed [SLOPE_W-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_NUM_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W:0]   rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic                 neg_q;
	logic [DIV_DEN_W:0]   sh;
	logic                 take;

	// shift in the next numerator bit and trial subtract
	assign sh   = {rem_q[DIV_DEN_W-1:0], quo_q[DIV_NUM_W-1]};
	assign take = sh >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= take ? (sh - {1'b0, den_q}) : sh;
			quo_q <= {quo_q[DIV_NUM_W-2:0], take};
		end
	end

	// saturate to the signed 32-bit range
	always_comb begin
		if (!neg_q) begin
			if (quo_q > DIV_NUM_W'(32'h7FFF_FFFF)) quot = 32'sh7FFF_FFFF;
			else                                    quot = $signed(quo_q[SLOPE_W-1:0]);
		end else begin
			if (quo_q > DIV_NUM_W'(33'h1_0000_0000 >> 1)) quot = 32'sh8000_0000;
			else                                           quot = $signed(-quo_q[SLOPE_W-1:0]);
		end
	end

	assign done = done_q;

endmodule

// ===== src/tupm_cell.sv =====
// ----------------------------------------------------------------------------
// tupm_cell
// One trapezoid slot: holds the scaled quad and tests the pixel as the
// test word passes through in two stages.
// ----------------------------------------------------------------------------
module tupm_cell import tupm_pkg::*; #(
	parameter int CELL_IDX   = 0,
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tupm_wr_t              wr,
	input  logic                  en,
	input  logic [COORD_BITS-1:0] px,
	input  logic [COORD_BITS-1:0] py,
	input  tupm_tok_t             tok_in,
	output tupm_tok_t             tok_out
);

	localparam int XQ_W  = COORD_BITS + 16;
	localparam int DX_W  = ((XQ_W > PXL_W) ? XQ_W : PXL_W) + 1;
	localparam int PR_W  = SLOPE_W + DX_W;
	localparam int ACC_W = PR_W + 2;

	logic [PXL_W-1:0]          left_q, right_q, tst_q, bst_q;
	logic signed [SLOPE_W-1:0] tsl_q, bsl_q;
	logic                      empty_q;

	tupm_tok_t                 tok_s1, tok_s2;
	logic                      ok_s1;
	logic signed [PR_W-1:0]    pt_s1, pb_s1;

	logic [XQ_W-1:0]           xq;
	logic signed [DX_W-1:0]    dx;
	logic                      c_left, c_right, sel;
	logic signed [ACC_W-1:0]   top, bot, lim_top, lim_bot;
	logic                      c_top, c_bot;

	assign sel = (CELL_IDX < 16) && (wr.slot == 4'(CELL_IDX));

	// slot storage, written by a load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
		end else if (wr.we && sel) begin
			empty_q <= wr.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we && sel) begin
			left_q  <= wr.left;
			right_q <= wr.right;
			tst_q   <= wr.tstart;
			bst_q   <= wr.bstart;
			tsl_q   <= wr.tslope;
			bsl_q   <= wr.bslope;
		end
	end

	// stage 1: side tests and edge products
	assign xq      = {px, 16'h0};
	assign dx      = $signed(DX_W'(xq)) - $signed(DX_W'(left_q));
	assign c_left  = (DX_W'(xq) + DX_W'(ONE_Q16)) > DX_W'(left_q);
	assign c_right = DX_W'(xq) < (DX_W'(right_q) + DX_W'(ONE_Q16));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1 <= en && !empty_q && c_left && c_right;
		pt_s1 <= PR_W'(tsl_q) * PR_W'(dx);
		pb_s1 <= PR_W'(bsl_q) * PR_W'(dx);
	end

	// stage 2: edge compares against the pixel row
	assign top     = $signed(ACC_W'({tst_q, 16'h0})) + ACC_W'(pt_s1);
	assign bot     = $signed(ACC_W'({bst_q, 16'h0})) + ACC_W'(pb_s1);
	assign lim_top = $signed(ACC_W'({(COORD_BITS+1)'(py) + 1'b1, 32'h0}));
	assign lim_bot = $signed(ACC_W'({py, 32'h0})) - $signed(ACC_W'({1'b1, 32'h0}));
	assign c_top   = top < lim_top;
	assign c_bot   = bot > lim_bot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
		end else begin
			tok_s2.vld <= tok_s1.vld;
			tok_s2.hit <= tok_s1.hit || (ok_s1 && c_top && c_bot);
		end
	end

	assign tok_out = tok_s2;

endmodule

// ===== src/trapezoid_union_pixel_mask_core.sv =====
// ----------------------------------------------------------------------------
// trapezoid_union_pixel_mask_core
// Table of trapezoids with a per-pixel union inside test.
// ----------------------------------------------------------------------------
// Input words (in_valid / in_stall) carry either a load (op 0) or a test
// (op 1). A load scales the quad to pixels and runs a serial divider twice,
// once per edge slope; a degenerate load skips the divider. A test word
// walks a chain of MAX_QUADS cells; on a hit the core loads the output
// register, on a miss it returns to idle.
// One word is in work at a time; in_stall is high while it is.
// A hit leaves through an output register (out_valid / out_stall); a miss
// leaves nothing.
// A stalled result holds, and the next input word is still
// taken; only a second hit waits for the register to drain.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at once; the user
// must make them only while the core is idle; the core does not check it.
// Loaded quads keep their scaled values. Reset marks every slot empty, sets
// tile and scan sizes to 64 and quad count to zero; no clearing pass needed.
// ----------------------------------------------------------------------------
`include "trapezoid_union_pixel_mask_core_assert.svh"

module trapezoid_union_pixel_mask_core import tupm_pkg::*; #(
	parameter int MAX_QUADS  = 16,
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [12:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [3:0]            quad_slot,
	input  logic [16:0]           left_x,
	input  logic [16:0]           right_x,
	input  logic [16:0]           top_left_y,
	input  logic [16:0]           top_right_y,
	input  logic [16:0]           bottom_left_y,
	input  logic [16:0]           bottom_right_y,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [23:0]           pixel_index
);

	localparam int IDX_W = ((COORD_BITS + 14) > 24) ? (COORD_BITS + 14) : 24;

	tupm_state_t state_q, state_d;

	logic [SIZE_W-1:0]  shape_w_q, shape_h_q, scan_w_q;
	logic [4:0]         quad_count_q;

	logic [3:0]         slot_q;
	logic [COORD_W-1:0] lx_q, rx_q, tl_q, tr_q, bl_q, br_q;
	logic [SIZE_W-1:0]  w_q, h_q;
	logic [PXL_W-1:0]   lpx_q, rpx_q, tpx_q, bpx_q;
	logic signed [DYH_W-1:0] dyht_q, dybh_q;
	logic               emp_q;
	logic               ld_emp;
	logic signed [SLOPE_W-1:0] tsl_q, bsl_q;

	logic [COORD_BITS-1:0] px_q, py_q;

	logic               in_acc, out_acc, out_load;
	logic               out_valid_q;
	logic [23:0]        pixel_index_q;
	logic [IDX_W-1:0]   idx_full;

	logic                      div_start, div_done, div_neg;
	logic [DIV_NUM_W-1:0]      div_num;
	logic [DIV_DEN_W-1:0]      div_den;
	logic signed [SLOPE_W-1:0] div_q;
	logic signed [DYH_W-1:0]   div_dyh;
	logic [DYH_W-1:0]          div_mag;

	tupm_wr_t           wr;
	tupm_tok_t          tok [MAX_QUADS+1];
	logic [MAX_QUADS:0] tok_vld;
	logic [MAX_QUADS-1:0] cell_en;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_w_q    <= 13'd64;
			shape_h_q    <= 13'd64;
			scan_w_q     <= 13'd64;
			quad_count_q <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHAPE_WIDTH:  shape_w_q    <= cfg_data;
				CFG_SHAPE_HEIGHT: shape_h_q    <= cfg_data;
				CFG_SCAN_WIDTH:   scan_w_q     <= cfg_data;
				CFG_QUAD_COUNT:   quad_count_q <= cfg_data[4:0];
				default:          ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = (op == OP_TEST) ? ST_TGO : ST_LMUL;
			ST_LMUL: state_d = ld_emp ? ST_LWR : ST_DTS;
			ST_DTS:  state_d = ST_DTW;
			ST_DTW:  if (div_done) state_d = ST_DBS;
			ST_DBS:  state_d = ST_DBW;
			ST_DBW:  if (div_done) state_d = ST_LWR;
			ST_LWR:  state_d = ST_IDLE;
			ST_TGO:  state_d = ST_TRUN;
			ST_TRUN: if (tok[MAX_QUADS].vld) state_d = tok[MAX_QUADS].hit ? ST_DONE : ST_IDLE;
			ST_DONE: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// control outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		div_start = (state_q == ST_DTS) || (state_q == ST_DBS);
		out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	// capture the input word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_q <= quad_slot;
			lx_q   <= sat_coord(left_x);
			rx_q   <= sat_coord(right_x);
			tl_q   <= sat_coord(top_left_y);
			tr_q   <= sat_coord(top_right_y);
			bl_q   <= sat_coord(bottom_left_y);
			br_q   <= sat_coord(bottom_right_y);
			w_q    <= sat_size(shape_w_q);
			h_q    <= sat_size(shape_h_q);
			px_q   <= pixel_x;
			py_q   <= pixel_y;
		end
	end

	// scale the quad to pixels
	assign ld_emp = (lx_q >= rx_q) || (w_q == '0);

	always_ff @(posedge clk) begin
		if (state_q == ST_LMUL) begin
			lpx_q  <= PXL_W'(lx_q * w_q);
			rpx_q  <= PXL_W'(rx_q * w_q);
			tpx_q  <= PXL_W'(tl_q * h_q);
			bpx_q  <= PXL_W'(bl_q * h_q);
			dyht_q <= DYH_W'(($signed({1'b0, tr_q}) - $signed({1'b0, tl_q}))
			          * $signed({1'b0, h_q}));
			dybh_q <= DYH_W'(($signed({1'b0, br_q}) - $signed({1'b0, bl_q}))
			          * $signed({1'b0, h_q}));
			emp_q  <= ld_emp;
		end
		if (state_q == ST_DTW && div_done) tsl_q <= div_q;
		if (state_q == ST_DBW && div_done) bsl_q <= div_q;
	end

	// divider operands: |dy*h| * 2^16 over the pixel width
	assign div_dyh = (state_q == ST_DBS) ? dybh_q : dyht_q;
	assign div_neg = div_dyh < 0;
	assign div_mag = div_neg ? DYH_W'(-div_dyh) : DYH_W'(div_dyh);
	assign div_num = {div_mag[DIV_NUM_W-17:0], 16'h0};
	assign div_den = rpx_q - lpx_q;

	tupm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.neg    (div_neg),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_q)
	);

	// slot write
	assign wr.we     = (state_q == ST_LWR);
	assign wr.slot   = slot_q;
	assign wr.left   = lpx_q;
	assign wr.right  = rpx_q;
	assign wr.tstart = tpx_q;
	assign wr.bstart = bpx_q;
	assign wr.tslope = tsl_q;
	assign wr.bslope = bsl_q;
	assign wr.empty  = emp_q;

	// cell chain
	assign tok[0].vld = (state_q == ST_TGO);
	assign tok[0].hit = 1'b0;

	for (genvar i = 0; i < MAX_QUADS; i++) begin : g_cell
		assign cell_en[i] = {4'b0, quad_count_q} > 9'(i);
		assign tok_vld[i] = tok[i].vld;

		tupm_cell #(
			.CELL_IDX   (i),
			.COORD_BITS (COORD_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.en      (cell_en[i]),
			.px      (px_q),
			.py      (py_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end
	assign tok_vld[MAX_QUADS] = tok[MAX_QUADS].vld;

	// raster index and output register
	assign idx_full = IDX_W'(py_q) * IDX_W'(scan_w_q) + IDX_W'(px_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) pixel_index_q <= idx_full[23:0];
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = pixel_index_q;

	// at most one test word in the chain
	`TUPM_ASSERT(a_one_word, clk, arst_n, $onehot0(tok_vld), "more than one test word in chain")
	// the chain end fires only while a test runs
	`TUPM_ASSERT(a_end_in_test, clk, arst_n, tok[MAX_QUADS].vld |-> state_q == ST_TRUN, "chain end outside test")
	// divider finishes only when a slope is awaited
	`TUPM_ASSERT(a_div_done, clk, arst_n, div_done |-> (state_q == ST_DTW || state_q == ST_DBW), "divider done unexpected")

endmodule

// ===== test/tupm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tupm_checker
// Watches the configuration port and both word channels of the trapezoid
// pixel mask core, keeps its own copy of the trapezoid table, predicts the
// raster index of every inside pixel and compares each result word in order.
// ----------------------------------------------------------------------------
module tupm_checker import tupm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        op,
	input  logic [3:0]  quad_slot,
	input  logic [16:0] left_x,
	input  logic [16:0] right_x,
	input  logic [16:0] top_left_y,
	input  logic [16:0] top_right_y,
	input  logic [16:0] bottom_left_y,
	input  logic [16:0] bottom_right_y,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [23:0] pixel_index,
	output int          errors,
	output int          pending
);

	localparam int NQ = 16;
	localparam int FIFO_DEPTH = 16;

	logic [12:0] tile_w, tile_h, row_len;
	logic [4:0]  active_quads;

	logic [28:0]        left_px [NQ];
	logic [28:0]        right_px [NQ];
	logic [28:0]        top_px [NQ];
	logic [28:0]        bot_px [NQ];
	logic signed [31:0] top_slope [NQ];
	logic signed [31:0] bot_slope [NQ];
	bit                 empty [NQ];

	// expected indexes, in order of arrival
	logic [23:0] want_fifo [FIFO_DEPTH];
	int          wr_cnt, rd_cnt;

	assign pending = wr_cnt - rd_cnt;

	function automatic longint clamp_coord(logic [16:0] v);
		return (v > 17'h10000) ? 65536 : longint'(v);
	endfunction

	function automatic longint clamp_size(logic [12:0] v);
		return (v > 13'd4096) ? 4096 : longint'(v);
	endfunction

	function automatic logic signed [31:0] edge_slope(longint dy, longint dx);
		longint q;
		q = (dy * 65536) / dx;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	// pixel against one slot, edges in Q.32 and sides in Q.16 so the compares are exact
	function automatic bit pixel_inside(int s, longint x, longint y);
		longint xq, yq, one32, d, t, b;
		xq = x * 65536;
		yq = y <<< 32;
		one32 = 64'sd1 <<< 32;
		d = xq - longint'(left_px[s]);
		t = longint'(top_px[s]) * 65536 + longint'(top_slope[s]) * d;
		b = longint'(bot_px[s]) * 65536 + longint'(bot_slope[s]) * d;
		return (xq + 65536 > longint'(left_px[s])) && (xq < longint'(right_px[s]) + 65536)
			&& (t - yq < one32) && (b - yq > -one32);
	endfunction

	// track config, load the table, queue expected indexes, compare results
	always @(posedge clk or negedge arst_n) begin
		longint w, h, lx, rx, tl, tr, bl, br, dx, n;
		bit hit;
		logic [23:0] want;
		if (!arst_n) begin
			tile_w <= 13'd64;
			tile_h <= 13'd64;
			row_len <= 13'd64;
			active_quads <= 5'd0;
			for (int i = 0; i < NQ; i++) empty[i] <= 1'b1;
			wr_cnt <= 0;
			rd_cnt <= 0;
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SHAPE_WIDTH: tile_w <= cfg_data;
					CFG_SHAPE_HEIGHT: tile_h <= cfg_data;
					CFG_SCAN_WIDTH: row_len <= cfg_data;
					CFG_QUAD_COUNT: active_quads <= cfg_data[4:0];
				endcase
			end
			if (in_valid && !in_stall) begin
				if (op == OP_LOAD) begin
					w = clamp_size(tile_w);
					h = clamp_size(tile_h);
					lx = clamp_coord(left_x);
					rx = clamp_coord(right_x);
					tl = clamp_coord(top_left_y);
					tr = clamp_coord(top_right_y);
					bl = clamp_coord(bottom_left_y);
					br = clamp_coord(bottom_right_y);
					left_px[quad_slot] <= 29'(lx * w);
					right_px[quad_slot] <= 29'(rx * w);
					top_px[quad_slot] <= 29'(tl * h);
					bot_px[quad_slot] <= 29'(bl * h);
					dx = rx * w - lx * w;
					if (lx >= rx || dx <= 0) begin
						top_slope[quad_slot] <= '0;
						bot_slope[quad_slot] <= '0;
						empty[quad_slot] <= 1'b1;
					end else begin
						top_slope[quad_slot] <= edge_slope((tr - tl) * h, dx);
						bot_slope[quad_slot] <= edge_slope((br - bl) * h, dx);
						empty[quad_slot] <= 1'b0;
					end
				end else begin
					n = (active_quads > 16) ? 16 : active_quads;
					hit = 0;
					for (int i = 0; i < n; i++)
						if (!empty[i] && pixel_inside(i, pixel_x, pixel_y)) hit = 1;
					if (hit) begin
						want_fifo[wr_cnt % FIFO_DEPTH] <=
							24'(longint'(pixel_y) * row_len + pixel_x);
						wr_cnt <= wr_cnt + 1;
					end
				end
			end
			if (out_valid && !out_stall) begin
				if (wr_cnt == rd_cnt) begin
					$display("%0t: unexpected word, expected none, actual pixel_index %0d",
						$time, pixel_index);
					errors <= errors + 1;
				end else begin
					want = want_fifo[rd_cnt % FIFO_DEPTH];
					rd_cnt <= rd_cnt + 1;
					if (pixel_index !== want) begin
						$display("%0t: pixel_index expected %0d, actual %0d",
							$time, want, pixel_index);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and pixel test words into the trapezoid pixel mask core over
// several tile and scan settings, with random gaps and output stalls; the
// checker predicts every hit and the top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import tupm_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int SETTLE = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = OP_LOAD;
	logic [3:0]  quad_slot = '0;
	logic [16:0] left_x = '0, right_x = '0;
	logic [16:0] top_left_y = '0, top_right_y = '0;
	logic [16:0] bottom_left_y = '0, bottom_right_y = '0;
	logic [11:0] pixel_x = '0, pixel_y = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [23:0] pixel_index;
	int          errors, pending;
	bit          quiet = 0;
	int          idle_cycles = 0;
	int          tile_px = 64;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	trapezoid_union_pixel_mask_core dut (.*);

	tupm_checker checker_i (.*);

	// stall the result side at random outside the quiet stretch
	always @(negedge clk)
		out_stall <= !quiet && ($urandom_range(99) < 18);

	// end the run when no word moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// hold one word until the core takes it, with an optional gap first
	task automatic send_word(logic o, logic [3:0] s, logic [16:0] lx, logic [16:0] rx,
			logic [16:0] tl, logic [16:0] tr, logic [16:0] bl, logic [16:0] br,
			logic [11:0] x, logic [11:0] y);
		int gap;
		if (!quiet && $urandom_range(99) < 18) begin
			gap = $urandom_range(1, 4);
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= o;
		quad_slot <= s;
		left_x <= lx;
		right_x <= rx;
		top_left_y <= tl;
		top_right_y <= tr;
		bottom_left_y <= bl;
		bottom_right_y <= br;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic load_quad(logic [3:0] s, logic [16:0] lx, logic [16:0] rx,
			logic [16:0] tl, logic [16:0] tr, logic [16:0] bl, logic [16:0] br);
		send_word(OP_LOAD, s, lx, rx, tl, tr, bl, br, 12'($urandom), 12'($urandom));
	endtask

	task automatic test_pixel(logic [11:0] x, logic [11:0] y);
		send_word(OP_TEST, 4'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
			17'($urandom), 17'($urandom), 17'($urandom), x, y);
	endtask

	// drain, let the core settle, then write all four registers
	task automatic set_config(int sw, int sh, int scan, int qc);
		@(negedge clk) in_valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SHAPE_WIDTH;
		cfg_data <= 13'(sw);
		@(negedge clk) cfg_index <= CFG_SHAPE_HEIGHT;
		cfg_data <= 13'(sh);
		@(negedge clk) cfg_index <= CFG_SCAN_WIDTH;
		cfg_data <= 13'(scan);
		@(negedge clk) cfg_index <= CFG_QUAD_COUNT;
		cfg_data <= 13'(qc);
		@(negedge clk) cfg_we <= 1'b0;
		tile_px = (sw > 4096) ? 4096 : sw;
	endtask

	// well-formed quad (left below right, top edge high, bottom edge low), or a fully random one a tenth of the time
	task automatic random_quad();
		logic [16:0] lx, rx;
		if ($urandom_range(99) < 10) begin
			load_quad(4'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
				17'($urandom), 17'($urandom), 17'($urandom));
		end else begin
			lx = 17'($urandom_range(0, 60000));
			rx = 17'(lx + $urandom_range(1, 65536 - lx));
			load_quad(4'($urandom), lx, rx, 17'($urandom_range(0, 40000)),
				17'($urandom_range(0, 40000)), 17'($urandom_range(20000, 65536)),
				17'($urandom_range(20000, 65536)));
		end
	endtask

	initial begin
		int sw[6] = '{64, 1, 4096, 0, 8191, 37};
		int sh[6] = '{64, 1, 4096, 17, 300, 8191};
		int sc[6] = '{64, 1, 4096, 8191, 100, 4095};
		int qc[6] = '{16, 1, 16, 31, 8, 0};
		int lim;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: tests with no quads, then sides, edges and slot extremes
		test_pixel(12'd0, 12'd0);
		set_config(64, 64, 64, 16);
		load_quad(4'd0, 17'h04000, 17'h0C000, 17'h04000, 17'h04000, 17'h0C000, 17'h0C000);
		test_pixel(12'd32, 12'd32);
		test_pixel(12'd15, 12'd15);
		test_pixel(12'd16, 12'd48);
		test_pixel(12'd49, 12'd32);
		test_pixel(12'd0, 12'd0);
		test_pixel(12'd4095, 12'd4095);
		load_quad(4'd1, 17'h08000, 17'h08000, 17'h0, 17'h0, 17'h10000, 17'h10000);
		load_quad(4'd2, 17'h0C000, 17'h04000, 17'h0, 17'h0, 17'h10000, 17'h10000);
		load_quad(4'd3, 17'h0, 17'h1FFFF, 17'h0, 17'h1FFFF, 17'h10000, 17'h00000);
		load_quad(4'd15, 17'h0, 17'h10000, 17'h0, 17'h0, 17'h10000, 17'h10000);
		test_pixel(12'd0, 12'd63);
		test_pixel(12'd63, 12'd1);
		test_pixel(12'd64, 12'd64);
		test_pixel(12'd10, 12'd60);
		test_pixel(12'd60, 12'd10);
		load_quad(4'd0, 17'h10000, 17'h0, 17'h0, 17'h0, 17'h0, 17'h0);

		// random phases over the register settings, extremes included
		for (int p = 0; p < 6; p++) begin
			set_config(sw[p], sh[p], sc[p], qc[p]);
			for (int i = 0; i < 170; i++) begin
				quiet = (p == 2 && i >= 40 && i < 140);
				lim = (tile_px + 2 > 4095) ? 4095 : tile_px + 2;
				if ($urandom_range(99) < 20)
					random_quad();
				else if ($urandom_range(99) < 85)
					test_pixel(12'($urandom_range(0, lim)),
						12'($urandom_range(0, 4095 < tile_px * 2 ?
						4095 : tile_px * 2 + 2)));
				else
					test_pixel(12'($urandom), 12'($urandom));
			end
			quiet = 0;
		end

		@(negedge clk) in_valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
